// File: design/assert_macros.svh
// Assertion macros for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define NPCM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication whose consequent holds in the next cycle.
`define NPCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/npcm_pkg.sv
package npcm_pkg;

  // Default palette depth.
  localparam int PALETTE_DEPTH_DEF = 256;

  // Field widths.
  localparam int CHAN_W     = 8;
  localparam int COLOR_W    = 8;
  localparam int DIST_W     = 18;
  localparam int SIZE_W     = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // Register reset values.
  localparam logic [SIZE_W-1:0] SIZE_RESET      = 9'd256;
  localparam logic [CHAN_W-1:0] THRESHOLD_RESET = 8'd128;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_SIZE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_THRESHOLD = 1'b1;

  // Item actions.
  localparam logic ACTION_STORE = 1'b0;
  localparam logic ACTION_MAP   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;     // write one palette entry from the input fields
    logic load;      // capture the pixel and arm the search
    logic clear;     // set the transparent result
    logic issue;     // read the next palette entry
    logic publish;   // move the result into the output register
  } npcm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_map;       // input item is a pixel
    logic transparent;  // input pixel alpha is below threshold
    logic last_issue;   // the entry read now is the last one in use
    logic pipe_busy;    // reads still in flight through the compare pipe
    logic out_free;     // output register can take a result this cycle
  } npcm_stat_t;

endpackage

// File: design/nearest_palette_color_mapper.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  action, entry_index, red, green, blue, alpha
// out       output     out_valid_o/out_stall_i color_index, best_distance
// cfg       input      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A store transaction writes its entry on acceptance. A transparent pixel sets the
// transparent result, then publishes it. An opaque pixel is accepted with the size
// clamped to 2..depth, then takes one palette memory read a cycle over entries 1 to
// size-1, drains the square and compare stages, then publishes when output is free.
// Reset clears the controller, the registers and the output valid; the palette
// is undefined until written. The output register lets the next transaction
// enter while a result is stalled; a new result waits until it drains.
module nearest_palette_color_mapper #(
  parameter int PALETTE_DEPTH = npcm_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            action_i,
  input  logic [7:0]                      entry_index_i,
  input  logic [npcm_pkg::CHAN_W-1:0]     red_i,
  input  logic [npcm_pkg::CHAN_W-1:0]     green_i,
  input  logic [npcm_pkg::CHAN_W-1:0]     blue_i,
  input  logic [npcm_pkg::CHAN_W-1:0]     alpha_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [npcm_pkg::COLOR_W-1:0]    color_index_o,
  output logic [npcm_pkg::DIST_W-1:0]     best_distance_o,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [npcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [npcm_pkg::CFG_DATA_W-1:0] cfg_data
);

  npcm_pkg::npcm_cmd_t  cmd;
  npcm_pkg::npcm_stat_t stat;

  // Registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  npcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  npcm_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_write_i     (cfg_valid && cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .action_i        (action_i),
    .entry_index_i   (entry_index_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .alpha_i         (alpha_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .color_index_o   (color_index_o),
    .best_distance_o (best_distance_o),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule

// File: design/npcm_ctrl.sv
module npcm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  npcm_pkg::npcm_stat_t stat_i,
  output npcm_pkg::npcm_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // Sequence one transaction at a time.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!stat_i.is_map) begin
            cmd_o.store = 1'b1;
          end else if (stat_i.transparent) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_FINISH;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/npcm_datapath.sv
module npcm_datapath #(
  parameter int PALETTE_DEPTH = npcm_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_write_i,
  input  logic [npcm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [npcm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              action_i,
  input  logic [7:0]                        entry_index_i,
  input  logic [npcm_pkg::CHAN_W-1:0]       red_i,
  input  logic [npcm_pkg::CHAN_W-1:0]       green_i,
  input  logic [npcm_pkg::CHAN_W-1:0]       blue_i,
  input  logic [npcm_pkg::CHAN_W-1:0]       alpha_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [npcm_pkg::COLOR_W-1:0]      color_index_o,
  output logic [npcm_pkg::DIST_W-1:0]       best_distance_o,
  input  npcm_pkg::npcm_cmd_t               cmd_i,
  output npcm_pkg::npcm_stat_t              stat_o
);

  localparam int IDX_W  = $clog2(PALETTE_DEPTH);
  localparam int CH     = npcm_pkg::CHAN_W;
  localparam int SQ_W   = 2 * npcm_pkg::CHAN_W;
  localparam int DW     = npcm_pkg::DIST_W;
  localparam int SW     = npcm_pkg::SIZE_W;

  // Configuration registers.
  logic [SW-1:0] size_q;
  logic [CH-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= npcm_pkg::SIZE_RESET;
      thr_q  <= npcm_pkg::THRESHOLD_RESET;
    end else if (cfg_write_i) begin
      unique case (cfg_index_i)
        npcm_pkg::REG_PALETTE_SIZE:    size_q <= cfg_data_i;
        npcm_pkg::REG_ALPHA_THRESHOLD: thr_q  <= cfg_data_i[CH-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the size to the range 2 to depth and take the last searched index.
  logic [SW-1:0]    lim_full;
  logic [IDX_W-1:0] lim;

  always_comb begin
    if (size_q < SW'(2)) begin
      lim_full = SW'(1);
    end else if (size_q > SW'(PALETTE_DEPTH)) begin
      lim_full = SW'(PALETTE_DEPTH - 1);
    end else begin
      lim_full = size_q - SW'(1);
    end
  end
  assign lim = lim_full[IDX_W-1:0];

  // Pixel and search bounds.
  logic [CH-1:0]    pr_q, pg_q, pb_q;
  logic [IDX_W-1:0] addr_q, lim_q;

  // Palette memory: one write port, one registered read port.
  logic [3*CH-1:0]  mem [PALETTE_DEPTH];
  logic [3*CH-1:0]  rdata_q;
  logic             wr_ok;

  assign wr_ok = ({1'b0, entry_index_i} < SW'(PALETTE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && wr_ok) begin
      mem[entry_index_i[IDX_W-1:0]] <= {red_i, green_i, blue_i};
    end
    if (cmd_i.issue) begin
      rdata_q <= mem[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pr_q   <= red_i;
      pg_q   <= green_i;
      pb_q   <= blue_i;
      lim_q  <= lim;
      addr_q <= IDX_W'(1);
    end else if (cmd_i.issue) begin
      addr_q <= addr_q + IDX_W'(1);
    end
  end

  // Track reads in flight through the compare pipe.
  logic             v1_q, v2_q;
  logic [IDX_W-1:0] idx1_q, idx2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= addr_q;
    idx2_q <= idx1_q;
  end

  // Square the channel differences.
  logic [CH-1:0]   dr, dg, db;
  logic [SQ_W-1:0] sqr_q, sqg_q, sqb_q;

  always_comb begin
    dr = (pr_q > rdata_q[3*CH-1:2*CH]) ? pr_q - rdata_q[3*CH-1:2*CH]
                                       : rdata_q[3*CH-1:2*CH] - pr_q;
    dg = (pg_q > rdata_q[2*CH-1:CH]) ? pg_q - rdata_q[2*CH-1:CH]
                                     : rdata_q[2*CH-1:CH] - pg_q;
    db = (pb_q > rdata_q[CH-1:0]) ? pb_q - rdata_q[CH-1:0]
                                  : rdata_q[CH-1:0] - pb_q;
  end

  always_ff @(posedge clk_i) begin
    sqr_q <= dr * dr;
    sqg_q <= dg * dg;
    sqb_q <= db * db;
  end

  // Sum and keep the strictly smaller distance, so the lowest index wins a tie.
  logic [DW-1:0]    sum_dist;
  logic [DW-1:0]    best_dist_q;
  logic [IDX_W-1:0] best_idx_q;

  assign sum_dist = DW'(sqr_q) + DW'(sqg_q) + DW'(sqb_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      best_dist_q <= '0;
      best_idx_q  <= '0;
    end else if (cmd_i.load) begin
      best_dist_q <= '1;
      best_idx_q  <= IDX_W'(1);
    end else if (v2_q && (sum_dist < best_dist_q)) begin
      best_dist_q <= sum_dist;
      best_idx_q  <= idx2_q;
    end
  end

  // Output register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      color_index_o   <= npcm_pkg::COLOR_W'(best_idx_q);
      best_distance_o <= best_dist_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Report status.
  assign stat_o.is_map      = (action_i == npcm_pkg::ACTION_MAP);
  assign stat_o.transparent = (alpha_i < thr_q);
  assign stat_o.last_issue  = (addr_q == lim_q);
  assign stat_o.pipe_busy   = v1_q || v2_q;
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

// File: design/npcm_checker.sv
`include "assert_macros.svh"

module npcm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            action_i,
  input logic [7:0]                      entry_index_i,
  input logic [npcm_pkg::CHAN_W-1:0]     red_i,
  input logic [npcm_pkg::CHAN_W-1:0]     green_i,
  input logic [npcm_pkg::CHAN_W-1:0]     blue_i,
  input logic [npcm_pkg::CHAN_W-1:0]     alpha_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [npcm_pkg::COLOR_W-1:0]    color_index_o,
  input logic [npcm_pkg::DIST_W-1:0]     best_distance_o,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [npcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [npcm_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Hold a stalled result.
  `NPCM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // Index zero only comes from a transparent pixel, at zero distance.
  `NPCM_ASSERT(a_zero_dist, clk_i, rst_ni, (out_valid_o && (color_index_o == '0)) |-> (best_distance_o == '0), "transparent result with nonzero distance")

  // A pixel transaction keeps the block busy, stalling the input, after it is accepted.
  `NPCM_ASSERT_NEXT(a_map_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && (action_i == npcm_pkg::ACTION_MAP), in_stall_o, "pixel did not occupy the block")

  // A store transaction leaves the input free in the cycle after it is accepted.
  `NPCM_ASSERT_NEXT(a_store_free, clk_i, rst_ni, in_valid_i && !in_stall_o && (action_i == npcm_pkg::ACTION_STORE), !in_stall_o, "store transaction blocked the input")

endmodule

bind nearest_palette_color_mapper npcm_checker u_npcm_checker (.*);

// File: tb/sv/nearest_palette_color_mapper_tb.sv
`timescale 1ns / 100ps

module nearest_palette_color_mapper_tb;

  localparam int DEPTH         = npcm_pkg::PALETTE_DEPTH_DEF;
  localparam int CH_W          = npcm_pkg::CHAN_W;
  localparam int CI_W          = npcm_pkg::COLOR_W;
  localparam int DI_W          = npcm_pkg::DIST_W;
  localparam int SZ_W          = npcm_pkg::SIZE_W;
  localparam int CIDX_W        = npcm_pkg::CFG_IDX_W;
  localparam int CDAT_W        = npcm_pkg::CFG_DATA_W;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 300;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 1_000_000;

  // One input transaction: a palette store or a pixel to map.
  typedef struct packed {
    logic            action;
    logic [7:0]      entry_index;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } npcm_op_t;

  // One output transaction.
  typedef struct packed {
    logic [CI_W-1:0] color_index;
    logic [DI_W-1:0] best_distance;
  } color_res_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  npcm_op_t              drv_op      = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [CI_W-1:0]       color_index_o;
  logic [DI_W-1:0]       best_distance_o;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CIDX_W-1:0]     cfg_index   = '0;
  logic [CDAT_W-1:0]     cfg_data    = '0;

  // Register copies and palette contents as the block sees them
  logic [SZ_W-1:0]       size_q   = npcm_pkg::SIZE_RESET;
  logic [CH_W-1:0]       thresh_q = npcm_pkg::THRESHOLD_RESET;
  logic [23:0]           pal_mem [DEPTH];

  // Palette contents as queued, used to keep pixels off unwritten entries
  logic [23:0]           queued_pal [DEPTH];
  bit                    queued_written [DEPTH];

  npcm_op_t              palette_ops [$];
  color_res_t            predicted_colors [$];
  int unsigned           ops_queued     = 0;
  int unsigned           ops_accepted   = 0;
  int unsigned           mismatch_count = 0;
  int unsigned           cycle_count    = 0;
  int unsigned           src_idle_pct   = 0;
  int unsigned           snk_stall_pct  = 0;
  int unsigned           hold_requests  = 0;
  int unsigned           hold_served    = 0;
  int unsigned           hold_left      = 0;

  nearest_palette_color_mapper u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (drv_op.action),
    .entry_index_i   (drv_op.entry_index),
    .red_i           (drv_op.red),
    .green_i         (drv_op.green),
    .blue_i          (drv_op.blue),
    .alpha_i         (drv_op.alpha),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .color_index_o   (color_index_o),
    .best_distance_o (best_distance_o),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // Clamp the size register to the searched range
  function automatic int entries_in_use(logic [SZ_W-1:0] sz);
    if (sz < 2) return 2;
    if (sz > DEPTH) return DEPTH;
    return int'(sz);
  endfunction

  // Nearest entry search over entries 1 to size-1, lowest index on a tie
  function automatic color_res_t map_pixel(npcm_op_t op);
    color_res_t  res;
    int unsigned sq_sum;
    int unsigned best;
    int          dr;
    int          dg;
    int          db;
    logic [23:0] e;
    res = '0;
    if (op.alpha < thresh_q) return res;
    best = 32'hFFFF_FFFF;
    for (int i = 1; i < entries_in_use(size_q); i++) begin
      e = pal_mem[i];
      dr = int'(op.red) - int'(e[23:16]);
      dg = int'(op.green) - int'(e[15:8]);
      db = int'(op.blue) - int'(e[7:0]);
      sq_sum = unsigned'(dr * dr + dg * dg + db * db);
      if (sq_sum < best) begin
        best = sq_sum;
        res.color_index = CI_W'(i);
      end
    end
    res.best_distance = best[DI_W-1:0];
    return res;
  endfunction

  // Driver: record accepted transactions, then offer the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      drv_op     <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        ops_accepted++;
        if (drv_op.action == npcm_pkg::ACTION_STORE) begin
          pal_mem[drv_op.entry_index] = {drv_op.red, drv_op.green, drv_op.blue};
        end else begin
          predicted_colors.push_back(map_pixel(drv_op));
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (palette_ops.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          drv_op     <= palette_ops.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each result with the oldest prediction, drive stall
  always @(posedge clk_i or negedge rst_ni) begin
    color_res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_colors.size() == 0) begin
          $error("result with no pixel pending: color_index %0d best_distance %0d",
                 color_index_o, best_distance_o);
          mismatch_count++;
        end else begin
          want = predicted_colors.pop_front();
          if (color_index_o !== want.color_index) begin
            $error("color_index: expected %0d, got %0d", want.color_index, color_index_o);
            mismatch_count++;
          end
          if (best_distance_o !== want.best_distance) begin
            $error("best_distance: expected %0d, got %0d",
                   want.best_distance, best_distance_o);
            mismatch_count++;
          end
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < snk_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CIDX_W-1:0] idx,
                           input logic [CDAT_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == npcm_pkg::REG_PALETTE_SIZE) begin
      size_q = val[SZ_W-1:0];
    end else begin
      thresh_q = val[CH_W-1:0];
    end
  endtask

  task automatic push_store(input logic [7:0] idx, input logic [23:0] rgb);
    npcm_op_t op;
    op.action      = npcm_pkg::ACTION_STORE;
    op.entry_index = idx;
    {op.red, op.green, op.blue} = rgb;
    op.alpha       = CH_W'($urandom());
    palette_ops.push_back(op);
    queued_pal[idx]     = rgb;
    queued_written[idx] = 1'b1;
    ops_queued++;
  endtask

  // Queue a pixel; an opaque one first gets every searched entry written
  task automatic push_pixel(input logic [23:0] rgb, input logic [CH_W-1:0] a);
    npcm_op_t op;
    if (a >= thresh_q) begin
      for (int k = 1; k < entries_in_use(size_q); k++) begin
        if (!queued_written[k]) push_store(k[7:0], 24'($urandom()));
      end
    end
    op.action      = npcm_pkg::ACTION_MAP;
    op.entry_index = 8'($urandom());
    {op.red, op.green, op.blue} = rgb;
    op.alpha       = a;
    palette_ops.push_back(op);
    ops_queued++;
  endtask

  // Hold until every transaction is accepted and every result is back
  task automatic wait_idle();
    while (ops_accepted != ops_queued || predicted_colors.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Configure, then queue random transactions under the given idling
  task automatic run_phase(input logic [CDAT_W-1:0] sz, input logic [CDAT_W-1:0] thr,
                           input int unsigned src, input int unsigned snk,
                           input int n, input bit hold);
    int          used;
    int          k;
    int unsigned sel;
    logic [7:0]  idx;
    logic [23:0] rgb;
    logic [7:0]  a;
    wait_idle();
    write_reg(npcm_pkg::REG_PALETTE_SIZE, sz);
    write_reg(npcm_pkg::REG_ALPHA_THRESHOLD, thr);
    src_idle_pct  = src;
    snk_stall_pct = snk;
    used = entries_in_use(size_q);
    for (int n_done = 0; n_done < n; n_done++) begin
      // pick a color: copy of an entry (ties, zero distance), extremes, or random
      sel = $urandom_range(9);
      if (sel < 3) begin
        k = int'($urandom_range(used - 1, 1));
        rgb = queued_written[k] ? queued_pal[k] : 24'($urandom());
      end else if (sel < 5) begin
        rgb = {$urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00,
               $urandom_range(1) ? 8'hFF : 8'h00};
      end else begin
        rgb = 24'($urandom());
      end
      if ($urandom_range(99) < 30) begin
        sel = $urandom_range(9);
        if (sel == 0) idx = 8'd0;
        else if (sel < 7) idx = 8'($urandom_range(used - 1, 1));
        else idx = 8'($urandom_range(255));
        push_store(idx, rgb);
      end else begin
        // alpha right at the threshold edge or anywhere
        sel = $urandom_range(9);
        if (sel < 2) a = thresh_q;
        else if (sel < 4) a = thresh_q - 8'd1;
        else a = 8'($urandom());
        push_pixel(rgb, a);
      end
    end
    if (hold) hold_requests++;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset registers: transparent pixels only, nothing written yet
    push_pixel(24'hFFFFFF, 8'd0);
    push_pixel(24'hFFFFFF, 8'd127);

    // Size below range, zero threshold: entry zero kept but not searched
    wait_idle();
    write_reg(npcm_pkg::REG_PALETTE_SIZE, 9'd1);
    write_reg(npcm_pkg::REG_ALPHA_THRESHOLD, 9'd0);
    push_store(8'd0, 24'hFFFFFF);
    push_store(8'd1, 24'h000000);
    push_pixel(24'hFFFFFF, 8'd0);
    push_pixel(24'h000000, 8'd255);

    wait_idle();
    write_reg(npcm_pkg::REG_PALETTE_SIZE, 9'd0);
    write_reg(npcm_pkg::REG_ALPHA_THRESHOLD, 9'd255);
    push_pixel(24'hC80A0A, 8'd254);
    push_pixel(24'h0A141E, 8'd255);

    // Duplicate entries for a tie, threshold one
    wait_idle();
    write_reg(npcm_pkg::REG_PALETTE_SIZE, 9'd4);
    write_reg(npcm_pkg::REG_ALPHA_THRESHOLD, 9'd1);
    push_store(8'd2, 24'hFFFFFF);
    push_store(8'd3, 24'h000000);
    push_pixel(24'h000000, 8'd1);
    push_pixel(24'hFF00FF, 8'd0);
    push_pixel(24'hFF00FF, 8'd200);
    push_store(8'd255, 24'h010203);
    push_pixel(24'h808080, 8'd255);
    push_pixel(24'hFFFFFF, 8'd128);

    // Random phases over sizes, thresholds and idling
    run_phase(9'd3, 9'd128, 0, 0, 30, 1'b1);
    run_phase(9'd9, 9'd0, 59, 0, 30, 1'b0);
    run_phase(9'd17, 9'd255, 0, 59, 30, 1'b0);
    run_phase(9'd33, 9'h14D, 9, 9, 30, 1'b0);
    run_phase(9'd511, 9'd64, 0, 0, 20, 1'b0);
    run_phase(9'd257, 9'($urandom_range(511)), 59, 59, 20, 1'b0);
    run_phase(9'd2, 9'd1, 0, 59, 25, 1'b0);
    run_phase(9'd1, 9'd200, 59, 0, 20, 1'b0);
    run_phase(9'($urandom_range(64, 2)), 9'($urandom_range(511)), 9, 9, 30, 1'b0);
    run_phase(9'($urandom_range(40, 2)), 9'($urandom_range(511)), 0, 0, 30, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
